[rtl/clnw_pkg.sv]
// ----------------------------------------------------------------------------
// Character LCD nibble writer package
// Shared types, codes and constants for the 4-bit LCD command sequencer.
// ----------------------------------------------------------------------------
package clnw_pkg;

	// Command codes of an input word.
	typedef enum logic [1:0] {
		CMD_INIT   = 2'd0,
		CMD_INSTR  = 2'd1,
		CMD_DATA   = 2'd2,
		CMD_CURSOR = 2'd3
	} cmd_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_POWERUP_WAIT = 2'd0,
		CFG_ENABLE_PULSE = 2'd1,
		CFG_SETTLE_WAIT  = 2'd2
	} cfg_idx_t;

	// Register reset values.
	localparam logic [7:0] POWERUP_WAIT_RST = 8'd15;
	localparam logic [7:0] ENABLE_PULSE_RST = 8'd1;
	localparam logic [7:0] SETTLE_WAIT_RST  = 8'd5;

	// Instruction register select codes.
	localparam logic RS_INSTR = 1'b0;
	localparam logic RS_DATA  = 1'b1;

	// Display addressing.
	localparam logic [7:0] SET_DDRAM_ADDR = 8'h80;
	localparam logic [6:0] ROW1_BASE      = 7'h40;

	// Init instruction sequence.
	localparam int unsigned INIT_LEN = 5;
	localparam int unsigned IDX_W    = $clog2(INIT_LEN);
	localparam logic [7:0] INIT_SEQ [INIT_LEN] = '{8'h02, 8'h28, 8'h0C, 8'h01, 8'h80};
	localparam logic [IDX_W-1:0] INIT_LAST = IDX_W'(INIT_LEN - 1);

	// Depth of the queue between front and back.
	localparam int unsigned QUEUE_DEPTH = 2;

	// One decoded job: a single byte, or the whole init sequence.
	typedef struct packed {
		logic       init;
		logic       rs;
		logic [7:0] value;
	} job_t;

	// Pin states of one byte, plus the power-up wait of init.
	typedef enum logic [6:0] {
		STEP_WAIT     = 7'b0000001,
		STEP_HI_SET   = 7'b0000010,
		STEP_HI_PULSE = 7'b0000100,
		STEP_HI_FALL  = 7'b0001000,
		STEP_LO_SET   = 7'b0010000,
		STEP_LO_PULSE = 7'b0100000,
		STEP_LO_FALL  = 7'b1000000
	} step_t;

	// Nibble bits 0..2 go to pins 0..2, bit 3 goes to pin 4.
	function automatic logic [4:0] nibble_pins(input logic [3:0] nib);
		return {nib[3], 1'b0, nib[2:0]};
	endfunction

endpackage

[rtl/clnw_if.sv]
// ----------------------------------------------------------------------------
// Character LCD nibble writer channels
// Valid/ready channels for command words and pin state words.
// ----------------------------------------------------------------------------
interface clnw_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] byte_value;
	logic [5:0] column;
	logic [7:0] row;

	modport source (output valid, cmd, byte_value, column, row, input ready);
	modport sink   (input valid, cmd, byte_value, column, row, output ready);
endinterface

interface clnw_pin_if;
	logic       valid;
	logic       ready;
	logic       reg_select;
	logic       enable;
	logic [4:0] bus_pins;
	logic [7:0] hold_ms;
	logic       last;

	modport source (output valid, reg_select, enable, bus_pins, hold_ms, last, input ready);
	modport sink   (input valid, reg_select, enable, bus_pins, hold_ms, last, output ready);
endinterface

[rtl/clnw_front.sv]
// ----------------------------------------------------------------------------
// Character LCD nibble writer front end
// Accepts command words and turns each into one job for the queue.
// ----------------------------------------------------------------------------
module clnw_front (
	clnw_cmd_if.sink      cmds,
	input  logic          q_ready,
	output logic          q_push,
	output clnw_pkg::job_t q_job
);
	import clnw_pkg::*;

	logic [6:0] addr;

	// A word is taken whenever the queue has room.
	assign cmds.ready = q_ready;
	assign q_push     = cmds.valid & q_ready;

	// Cursor address: row 0 from zero, row 1 from the second line base, else zero.
	always_comb begin
		if (cmds.row == 8'd0) begin
			addr = {1'b0, cmds.column};
		end else if (cmds.row == 8'd1) begin
			addr = ROW1_BASE | {1'b0, cmds.column};
		end else begin
			addr = 7'd0;
		end
	end

	// Classify the command.
	always_comb begin
		q_job = '0;
		unique case (cmd_t'(cmds.cmd))
			CMD_INIT: begin
				q_job.init  = 1'b1;
				q_job.rs    = RS_INSTR;
				q_job.value = 8'd0;
			end
			CMD_INSTR: begin
				q_job.rs    = RS_INSTR;
				q_job.value = cmds.byte_value;
			end
			CMD_DATA: begin
				q_job.rs    = RS_DATA;
				q_job.value = cmds.byte_value;
			end
			CMD_CURSOR: begin
				q_job.rs    = RS_INSTR;
				q_job.value = SET_DDRAM_ADDR | {1'b0, addr};
			end
			default: begin
				q_job = '0;
			end
		endcase
	end

endmodule

[rtl/clnw_queue.sv]
// ----------------------------------------------------------------------------
// Character LCD nibble writer job queue
// Short first-in first-out buffer between the front end and the sequencer.
// ----------------------------------------------------------------------------
module clnw_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  clnw_pkg::job_t push_job,
	output logic           ready,
	input  logic           pop,
	output clnw_pkg::job_t pop_job,
	output logic           valid
);
	import clnw_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	job_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign ready   = (count_q != CNT_FULL);
	assign valid   = (count_q != '0);
	assign pop_job = slot_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/clnw_back.sv]
// ----------------------------------------------------------------------------
// Character LCD nibble writer sequencer
// Steps through the pin states of each job into a registered output word.
// ----------------------------------------------------------------------------
module clnw_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     powerup_wait_ms,
	input  logic [7:0]     enable_pulse_ms,
	input  logic [7:0]     settle_wait_ms,
	input  logic           q_valid,
	input  clnw_pkg::job_t q_job,
	output logic           q_pop,
	clnw_pin_if.source     pins
);
	import clnw_pkg::*;

	logic             busy_q;
	logic             init_q;
	logic             rs_q;
	logic [7:0]       value_q;
	logic [IDX_W-1:0] idx_q;
	step_t            step_q;

	logic             out_valid_q;
	logic             out_rs_q;
	logic             out_en_q;
	logic [4:0]       out_pins_q;
	logic [7:0]       out_hold_q;
	logic             out_last_q;

	logic             adv;
	logic             is_last;
	logic [7:0]       cur_byte;
	logic [4:0]       hi_pins;
	logic [4:0]       lo_pins;
	logic             nx_en;
	logic [4:0]       nx_pins;
	logic [7:0]       nx_hold;
	step_t            nx_step;

	// A new state is made whenever the output word is free or being taken.
	assign adv     = busy_q & (~out_valid_q | pins.ready);
	assign is_last = (step_q == STEP_LO_FALL) & (~init_q | (idx_q == INIT_LAST));
	assign q_pop   = q_valid & (~busy_q | (adv & is_last));

	assign cur_byte = init_q ? INIT_SEQ[idx_q] : value_q;
	assign hi_pins  = nibble_pins(cur_byte[7:4]);
	assign lo_pins  = nibble_pins(cur_byte[3:0]);

	// Pin state for the current step and the step that follows.
	always_comb begin
		nx_en   = 1'b0;
		nx_pins = '0;
		nx_hold = 8'd0;
		nx_step = STEP_HI_SET;
		unique case (step_q)
			STEP_WAIT: begin
				nx_hold = powerup_wait_ms;
				nx_step = STEP_HI_SET;
			end
			STEP_HI_SET: begin
				nx_pins = hi_pins;
				nx_step = STEP_HI_PULSE;
			end
			STEP_HI_PULSE: begin
				nx_en   = 1'b1;
				nx_pins = hi_pins;
				nx_hold = enable_pulse_ms;
				nx_step = STEP_HI_FALL;
			end
			STEP_HI_FALL: begin
				nx_pins = hi_pins;
				nx_step = STEP_LO_SET;
			end
			STEP_LO_SET: begin
				nx_pins = lo_pins;
				nx_step = STEP_LO_PULSE;
			end
			STEP_LO_PULSE: begin
				nx_en   = 1'b1;
				nx_pins = lo_pins;
				nx_hold = enable_pulse_ms;
				nx_step = STEP_LO_FALL;
			end
			STEP_LO_FALL: begin
				nx_pins = lo_pins;
				nx_hold = settle_wait_ms;
				nx_step = STEP_HI_SET;
			end
			default: begin
				nx_step = STEP_HI_SET;
			end
		endcase
	end

	// Job state: loaded on pop, stepped on every advance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			init_q  <= 1'b0;
			rs_q    <= RS_INSTR;
			value_q <= '0;
			idx_q   <= '0;
			step_q  <= STEP_HI_SET;
		end else if (q_pop) begin
			busy_q  <= 1'b1;
			init_q  <= q_job.init;
			rs_q    <= q_job.rs;
			value_q <= q_job.value;
			idx_q   <= '0;
			step_q  <= q_job.init ? STEP_WAIT : STEP_HI_SET;
		end else if (adv) begin
			if (is_last) begin
				busy_q <= 1'b0;
			end
			if (step_q == STEP_LO_FALL) begin
				idx_q <= idx_q + 1'b1;
			end
			step_q <= nx_step;
		end
	end

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (pins.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_rs_q   <= rs_q;
			out_en_q   <= nx_en;
			out_pins_q <= nx_pins;
			out_hold_q <= nx_hold;
			out_last_q <= is_last;
		end
	end

	assign pins.valid      = out_valid_q;
	assign pins.reg_select = out_rs_q;
	assign pins.enable     = out_en_q;
	assign pins.bus_pins   = out_pins_q;
	assign pins.hold_ms    = out_hold_q;
	assign pins.last       = out_last_q;

endmodule

[rtl/char_lcd_nibble_writer.sv]
// ----------------------------------------------------------------------------
// Character LCD nibble writer
// Turns display commands into timed pin states for a 4-bit LCD bus.
// ----------------------------------------------------------------------------
// Usage:
//   cmds carries one command word: init, instruction byte, data byte or
//   cursor move. pin_states carries one pin state word per cycle at most:
//   register select, enable level, bus pins, hold time in ms and a last flag.
//   A byte command gives 6 words; init gives 31 (power-up wait, then five
//   instruction bytes). The hold times come from the configuration port.
//   An accepted command goes through the queue and the job state registers
//   into the output word register. Throughput is one word per cycle while jobs
//   wait and the receiver is ready; the single sequencer sets that rate.
//   A two-entry job queue sits between the command decoder and the
//   sequencer, so commands keep being taken while words wait downstream.
//   When the receiver stalls, the output word holds and the sequencer waits;
//   commands are taken until the queue is full.
//   Reset clears the queue and the sequencer and loads the default waits
//   (15 ms power-up, 1 ms enable pulse, 5 ms settle). Configuration must be
//   written only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	clnw_cmd_if.sink    cmds,
	clnw_pin_if.source  pin_states
);
	import clnw_pkg::*;

	logic [7:0] powerup_wait_q;
	logic [7:0] enable_pulse_q;
	logic [7:0] settle_wait_q;

	logic q_push;
	logic q_ready;
	logic q_pop;
	logic q_valid;
	job_t push_job;
	job_t pop_job;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			powerup_wait_q <= POWERUP_WAIT_RST;
			enable_pulse_q <= ENABLE_PULSE_RST;
			settle_wait_q  <= SETTLE_WAIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_POWERUP_WAIT: powerup_wait_q <= cfg_data;
				CFG_ENABLE_PULSE: enable_pulse_q <= cfg_data;
				CFG_SETTLE_WAIT:  settle_wait_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	clnw_front u_front (
		.cmds    (cmds),
		.q_ready (q_ready),
		.q_push  (q_push),
		.q_job   (push_job)
	);

	clnw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.ready    (q_ready),
		.pop      (q_pop),
		.pop_job  (pop_job),
		.valid    (q_valid)
	);

	clnw_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.powerup_wait_ms (powerup_wait_q),
		.enable_pulse_ms (enable_pulse_q),
		.settle_wait_ms  (settle_wait_q),
		.q_valid         (q_valid),
		.q_job           (pop_job),
		.q_pop           (q_pop),
		.pins            (pin_states)
	);

endmodule

[dv/char_lcd_nibble_writer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character LCD nibble writer testbench
// Sends init, instruction, data and cursor commands under several hold time
// settings. Each pin state word that comes out is checked, field by field,
// against a word list that a behavioral copy of the sequencer builds.
// Both channels idle at random.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer_tb;
	import clnw_pkg::*;

	localparam int unsigned IDLE_LIMIT  = 2000;
	localparam int unsigned PHASE_ITEMS = 75;
	localparam int unsigned N_PHASES    = 6;
	localparam int unsigned N_DIRECTED  = 20;

	// One expected pin state word.
	typedef struct packed {
		logic       rs;
		logic       en;
		logic [4:0] pins;
		logic [7:0] hold;
		logic       last;
	} pin_word_t;

	// One directed command; known_byte is the byte on the bus when known is set.
	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] byte_value;
		logic [5:0] column;
		logic [7:0] row;
		logic       known;
		logic [7:0] known_byte;
	} dir_row_t;

	logic           clk;
	logic           arst_n;
	logic           cfg_we;
	cfg_idx_t       cfg_index;
	logic [7:0]     cfg_data;

	clnw_cmd_if     cmd_ch ();
	clnw_pin_if     pin_ch ();

	// Local copy of the hold time registers.
	logic [7:0]     powerup_ms;
	logic [7:0]     pulse_ms;
	logic [7:0]     settle_ms;

	pin_word_t      pin_expect [$];
	int unsigned    errors;
	int unsigned    quiet_cycles;
	bit             idle_on;

	// Bytes that init sends after the power-up wait.
	logic [7:0]     init_bytes [5];

	dir_row_t dir_rows [N_DIRECTED] = '{
		'{CMD_INIT,   8'h00, 6'd0,  8'd0,   1'b0, 8'h00},
		'{CMD_INSTR,  8'h00, 6'd0,  8'd0,   1'b1, 8'h00},
		'{CMD_INSTR,  8'hFF, 6'd0,  8'd0,   1'b1, 8'hFF},
		'{CMD_DATA,   8'h00, 6'd0,  8'd0,   1'b1, 8'h00},
		'{CMD_DATA,   8'hFF, 6'd63, 8'd255, 1'b1, 8'hFF},
		'{CMD_DATA,   8'hA5, 6'd0,  8'd0,   1'b1, 8'hA5},
		'{CMD_DATA,   8'h5A, 6'd0,  8'd0,   1'b1, 8'h5A},
		'{CMD_CURSOR, 8'h00, 6'd0,  8'd0,   1'b1, 8'h80},
		'{CMD_CURSOR, 8'h00, 6'd63, 8'd0,   1'b1, 8'hBF},
		'{CMD_CURSOR, 8'h00, 6'd0,  8'd1,   1'b1, 8'hC0},
		'{CMD_CURSOR, 8'hFF, 6'd63, 8'd1,   1'b1, 8'hFF},
		'{CMD_CURSOR, 8'h00, 6'd5,  8'd2,   1'b1, 8'h80},
		'{CMD_CURSOR, 8'h00, 6'd63, 8'd255, 1'b1, 8'h80},
		'{CMD_CURSOR, 8'h00, 6'd17, 8'd128, 1'b1, 8'h80},
		'{CMD_INSTR,  8'h3C, 6'd63, 8'd255, 1'b1, 8'h3C},
		'{CMD_DATA,   8'h81, 6'd21, 8'd1,   1'b1, 8'h81},
		'{CMD_CURSOR, 8'hFF, 6'd42, 8'd0,   1'b1, 8'hAA},
		'{CMD_INIT,   8'hFF, 6'd63, 8'd255, 1'b0, 8'h00},
		'{CMD_INSTR,  8'h88, 6'd0,  8'd0,   1'b1, 8'h88},
		'{CMD_DATA,   8'h77, 6'd0,  8'd0,   1'b1, 8'h77}
	};

	char_lcd_nibble_writer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmds       (cmd_ch.sink),
		.pin_states (pin_ch.source)
	);

	// Clock.
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Pin levels for one nibble: bit 3 moves up to pin 4.
	function automatic logic [4:0] bus_of_nibble(input logic [3:0] nib);
		logic [4:0] pins;
		pins = {2'b00, nib[2:0]};
		if (nib[3])
			pins = pins | 5'h10;
		return pins;
	endfunction

	// Queues the six pin state words of one byte.
	task automatic queue_byte_words(input logic rs, input logic [7:0] b, input logic tail);
		logic [4:0] hi;
		logic [4:0] lo;
		hi = bus_of_nibble(b[7:4]);
		lo = bus_of_nibble(b[3:0]);
		pin_expect.push_back('{rs, 1'b0, hi, 8'd0, 1'b0});
		pin_expect.push_back('{rs, 1'b1, hi, pulse_ms, 1'b0});
		pin_expect.push_back('{rs, 1'b0, hi, 8'd0, 1'b0});
		pin_expect.push_back('{rs, 1'b0, lo, 8'd0, 1'b0});
		pin_expect.push_back('{rs, 1'b1, lo, pulse_ms, 1'b0});
		pin_expect.push_back('{rs, 1'b0, lo, settle_ms, tail});
	endtask

	// Builds the words that one command must produce.
	task automatic predict_pin_words(input cmd_t c, input logic [7:0] b,
		input logic [5:0] col, input logic [7:0] rw);
		logic [6:0] addr;
		case (c)
			CMD_INIT: begin
				pin_expect.push_back('{RS_INSTR, 1'b0, 5'd0, powerup_ms, 1'b0});
				for (int i = 0; i < 5; i++)
					queue_byte_words(RS_INSTR, init_bytes[i], i == 4);
			end
			CMD_INSTR: queue_byte_words(RS_INSTR, b, 1'b1);
			CMD_DATA:  queue_byte_words(RS_DATA, b, 1'b1);
			default: begin
				// Rows other than the first two fall back to address zero.
				addr = 7'd0;
				if (rw == 8'd0)
					addr = {1'b0, col};
				else if (rw == 8'd1)
					addr = 7'h40 + {1'b0, col};
				queue_byte_words(RS_INSTR, {1'b1, addr}, 1'b1);
			end
		endcase
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("ERROR at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
		errors++;
	endtask

	// Idle length: mostly none or short, now and then long.
	function automatic int gap_len();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Writes one register and mirrors it locally.
	task automatic write_reg(input cfg_idx_t idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_POWERUP_WAIT: powerup_ms = val;
			CFG_ENABLE_PULSE: pulse_ms   = val;
			default:          settle_ms  = val;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Presents one command word and returns at the edge that takes it.
	// Called right after a rising edge.
	task automatic push_cmd(input cmd_t c, input logic [7:0] b, input logic [5:0] col,
		input logic [7:0] rw, input logic known, input logic [7:0] known_byte);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.cmd        <= c;
		cmd_ch.byte_value <= b;
		cmd_ch.column     <= col;
		cmd_ch.row        <= rw;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		if (known)
			queue_byte_words((c == CMD_DATA) ? RS_DATA : RS_INSTR, known_byte, 1'b1);
		else
			predict_pin_words(c, b, col, rw);
	endtask

	// Lets every outstanding word drain, then a few more cycles.
	task automatic drain_words();
		while (pin_expect.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Random command: mostly byte commands, cursor rows mostly in range.
	task automatic push_random_cmd();
		int r;
		cmd_t c;
		logic [7:0] rw;
		r = $urandom_range(0, 99);
		if (r < 8)
			c = CMD_INIT;
		else if (r < 35)
			c = CMD_INSTR;
		else if (r < 70)
			c = CMD_DATA;
		else
			c = CMD_CURSOR;
		rw = 8'($urandom_range(0, 255));
		if (c == CMD_CURSOR && $urandom_range(0, 99) < 80)
			rw = 8'($urandom_range(0, 1));
		push_cmd(c, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)), rw, 1'b0, 8'h00);
	endtask

	// Stimulus and end of run.
	initial begin
		logic [7:0] p;
		logic [7:0] e;
		logic [7:0] s;
		init_bytes = '{8'h02, 8'h28, 8'h0C, 8'h01, 8'h80};
		powerup_ms = 8'd15;
		pulse_ms   = 8'd1;
		settle_ms  = 8'd5;
		errors     = 0;
		idle_on    = 1'b1;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = CFG_POWERUP_WAIT;
		cfg_data   = 8'd0;
		cmd_ch.valid      = 1'b0;
		cmd_ch.cmd        = CMD_INIT;
		cmd_ch.byte_value = 8'd0;
		cmd_ch.column     = 6'd0;
		cmd_ch.row        = 8'd0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed commands under the reset hold times.
		for (int i = 0; i < N_DIRECTED; i++)
			push_cmd(dir_rows[i].cmd, dir_rows[i].byte_value, dir_rows[i].column,
				dir_rows[i].row, dir_rows[i].known, dir_rows[i].known_byte);
		cmd_ch.valid <= 1'b0;
		drain_words();

		// Random phases, each under its own hold times.
		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				0: begin p = 8'd0;   e = 8'd0;   s = 8'd0;   end
				1: begin p = 8'd255; e = 8'd255; s = 8'd255; end
				2: begin p = 8'd0;   e = 8'd255; s = 8'd0;   end
				default: begin
					p = 8'($urandom_range(0, 255));
					e = 8'($urandom_range(0, 255));
					s = 8'($urandom_range(0, 255));
				end
			endcase
			write_reg(CFG_POWERUP_WAIT, p);
			write_reg(CFG_ENABLE_PULSE, e);
			write_reg(CFG_SETTLE_WAIT, s);
			@(posedge clk);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Some stretches run with no idling on either side.
				if (n % 25 == 0)
					idle_on = (ph != 2) && ($urandom_range(0, 3) != 0);
				push_random_cmd();
			end
			cmd_ch.valid <= 1'b0;
			idle_on = 1'b1;
			drain_words();
		end

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Receiver: checks each accepted word and stalls at random.
	initial begin
		pin_word_t want;
		int stall_left;
		pin_ch.ready = 1'b0;
		stall_left   = 0;
		forever begin
			@(posedge clk);
			if (arst_n && pin_ch.valid && pin_ch.ready) begin
				if (pin_expect.size() == 0) begin
					report_mismatch("unexpected word, hold_ms", pin_ch.hold_ms, 0);
				end else begin
					want = pin_expect.pop_front();
					if (pin_ch.reg_select !== want.rs)
						report_mismatch("reg_select", pin_ch.reg_select, want.rs);
					if (pin_ch.enable !== want.en)
						report_mismatch("enable", pin_ch.enable, want.en);
					if (pin_ch.bus_pins !== want.pins)
						report_mismatch("bus_pins", pin_ch.bus_pins, want.pins);
					if (pin_ch.hold_ms !== want.hold)
						report_mismatch("hold_ms", pin_ch.hold_ms, want.hold);
					if (pin_ch.last !== want.last)
						report_mismatch("last", pin_ch.last, want.last);
				end
			end
			if (!arst_n) begin
				pin_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				pin_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				pin_ch.ready <= 1'b1;
				if ($urandom_range(0, 99) < 30)
					stall_left = gap_len();
			end
		end
	end

	// Watchdog: ends the run when no word moves for too long.
	initial quiet_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (pin_ch.valid && pin_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

endmodule
